### rtl/core/npcs_pkg.sv
package npcs_pkg;

   localparam int FIELD_BITS = 8;
   localparam int INDEX_FIELD_BITS = 8;
   localparam int COUNT_BITS = 9;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 9'd256;

   typedef enum logic [0:0] {
      CMD_WRITE = 1'b0,
      CMD_MAP   = 1'b1
   } cmd_type;

   // control that travels with each transaction down the chain
   typedef struct packed {
      logic                        valid;
      cmd_type                     cmd;
      logic                        have;  // best_dist/best_idx hold a candidate
      logic                        pend;  // pend_dist holds the previous entry's distance
      logic [FIELD_BITS-1:0]       entry_index;
   } ctl_type;

endpackage

### rtl/core/npcs_if.sv
interface npcs_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] entry_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, command, entry_index, red, green, blue, input ready);
   modport sink (input valid, command, entry_index, red, green, blue, output ready);
endinterface

interface npcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] best_index;

   modport source (output valid, best_index, input ready);
   modport sink (input valid, best_index, output ready);
endinterface

interface npcs_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### rtl/core/npcs_cell.sv
module npcs_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CHANNEL_BITS = 8,
   parameter int INDEX_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [npcs_pkg::COUNT_BITS-1:0]     color_count,
   input  npcs_pkg::ctl_type                   ctl_i,
   input  logic [CHANNEL_BITS-1:0]             red_i,
   input  logic [CHANNEL_BITS-1:0]             green_i,
   input  logic [CHANNEL_BITS-1:0]             blue_i,
   input  logic [2*CHANNEL_BITS+1:0]           best_dist_i,
   input  logic [INDEX_BITS-1:0]               best_idx_i,
   input  logic [2*CHANNEL_BITS+1:0]           pend_dist_i,
   output npcs_pkg::ctl_type                   ctl_o,
   output logic [CHANNEL_BITS-1:0]             red_o,
   output logic [CHANNEL_BITS-1:0]             green_o,
   output logic [CHANNEL_BITS-1:0]             blue_o,
   output logic [2*CHANNEL_BITS+1:0]           best_dist_o,
   output logic [INDEX_BITS-1:0]               best_idx_o,
   output logic [2*CHANNEL_BITS+1:0]           pend_dist_o
);

   localparam int DIST_BITS = 2 * CHANNEL_BITS + 2;
   localparam logic [INDEX_BITS-1:0] PREV_INDEX =
      INDEX_BITS'((CELL_INDEX == 0) ? 0 : CELL_INDEX - 1);

   // palette entry owned by this cell
   logic [CHANNEL_BITS-1:0] ent_red_ff, ent_green_ff, ent_blue_ff;

   npcs_pkg::ctl_type       ctl_ff, ctl_in;
   logic [CHANNEL_BITS-1:0] red_ff, green_ff, blue_ff;
   logic [DIST_BITS-1:0]    best_dist_ff, best_dist_in;
   logic [INDEX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [DIST_BITS-1:0]    pend_dist_ff, pend_dist_in;

   logic                    is_map, is_write, in_range, take_prev;
   logic [CHANNEL_BITS-1:0] dr, dg, db;
   logic [2*CHANNEL_BITS-1:0] sr, sg, sb;

   always_comb begin
      is_map   = ctl_i.valid && (ctl_i.cmd == npcs_pkg::CMD_MAP);
      is_write = ctl_i.valid && (ctl_i.cmd == npcs_pkg::CMD_WRITE)
                 && (int'(ctl_i.entry_index) == CELL_INDEX);
      in_range = CELL_INDEX < int'(color_count);

      // fold the previous cell's distance into the running best
      take_prev = ctl_i.pend && (!ctl_i.have || (pend_dist_i < best_dist_i));
      if (take_prev) begin
         best_dist_in = pend_dist_i;
         best_idx_in  = PREV_INDEX;
      end else begin
         best_dist_in = best_dist_i;
         best_idx_in  = best_idx_i;
      end

      // squared distance to this cell's entry, folded one cell later
      dr = (red_i > ent_red_ff) ? red_i - ent_red_ff : ent_red_ff - red_i;
      dg = (green_i > ent_green_ff) ? green_i - ent_green_ff : ent_green_ff - green_i;
      db = (blue_i > ent_blue_ff) ? blue_i - ent_blue_ff : ent_blue_ff - blue_i;
      sr = dr * dr;
      sg = dg * dg;
      sb = db * db;
      pend_dist_in = DIST_BITS'(sr) + DIST_BITS'(sg) + DIST_BITS'(sb);

      ctl_in      = ctl_i;
      ctl_in.have = ctl_i.have || take_prev;
      ctl_in.pend = is_map && in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff       <= red_i;
         green_ff     <= green_i;
         blue_ff      <= blue_i;
         best_dist_ff <= best_dist_in;
         best_idx_ff  <= best_idx_in;
         pend_dist_ff <= pend_dist_in;
         if (is_write) begin
            ent_red_ff   <= red_i;
            ent_green_ff <= green_i;
            ent_blue_ff  <= blue_i;
         end
      end
   end

   assign ctl_o       = ctl_ff;
   assign red_o       = red_ff;
   assign green_o     = green_ff;
   assign blue_o      = blue_ff;
   assign best_dist_o = best_dist_ff;
   assign best_idx_o  = best_idx_ff;
   assign pend_dist_o = pend_dist_ff;

endmodule

### rtl/core/npcs_tail.sv
module npcs_tail #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int CHANNEL_BITS = 8,
   parameter int INDEX_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  npcs_pkg::ctl_type         ctl_i,
   input  logic [2*CHANNEL_BITS+1:0] best_dist_i,
   input  logic [INDEX_BITS-1:0]     best_idx_i,
   input  logic [2*CHANNEL_BITS+1:0] pend_dist_i,
   output logic                      advance,
   npcs_rsp_if.source                rsp_bus
);

   localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(PALETTE_ENTRIES - 1);

   logic                                   out_valid_ff;
   logic [npcs_pkg::INDEX_FIELD_BITS-1:0]  best_index_ff, best_index_in;
   logic [INDEX_BITS-1:0]                  final_idx;
   logic [INDEX_BITS+npcs_pkg::INDEX_FIELD_BITS-1:0] idx_wide;

   always_comb begin
      if (ctl_i.pend && (!ctl_i.have || (pend_dist_i < best_dist_i))) begin
         final_idx = LAST_INDEX;
      end else begin
         final_idx = best_idx_i;
      end
      idx_wide      = {{npcs_pkg::INDEX_FIELD_BITS{1'b0}}, final_idx};
      best_index_in = idx_wide[npcs_pkg::INDEX_FIELD_BITS-1:0];
   end

   // whole chain moves when the output register is free or being drained
   assign advance = !out_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= ctl_i.valid && (ctl_i.cmd == npcs_pkg::CMD_MAP);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         best_index_ff <= best_index_in;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.best_index = best_index_ff;

endmodule

### rtl/core/nearest_palette_color_search_top.sv
// A map passes through every cell and then the tail's output register before response valid.
// Throughput: one transaction (write or map) per cycle, set by the cell chain
//   moving one position per cycle; the chain stalls only on response backpressure.
// Reset (synchronous, active high) clears the chain's valid bits and the output valid bit
//   and sets color_count to 256; palette contents stay undefined until written.
module nearest_palette_color_search_top #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int CHANNEL_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   npcs_req_if.sink   req_bus,
   npcs_rsp_if.source rsp_bus,
   npcs_csr_if.sink   csr_bus
);

   localparam int INDEX_BITS = $clog2(PALETTE_ENTRIES);
   localparam int DIST_BITS  = 2 * CHANNEL_BITS + 2;

   // search length register; write it only while the chain is empty (the block does not enforce this)
   logic [npcs_pkg::COUNT_BITS-1:0] color_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_count_ff <= npcs_pkg::COUNT_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         color_count_ff <= csr_bus.data;
      end
   end

   assign csr_bus.ready = 1'b1;

   // chain links: position k feeds cell k, position PALETTE_ENTRIES feeds the tail
   npcs_pkg::ctl_type       ctl_chain       [0:PALETTE_ENTRIES];
   logic [CHANNEL_BITS-1:0] red_chain       [0:PALETTE_ENTRIES];
   logic [CHANNEL_BITS-1:0] green_chain     [0:PALETTE_ENTRIES];
   logic [CHANNEL_BITS-1:0] blue_chain      [0:PALETTE_ENTRIES];
   logic [DIST_BITS-1:0]    best_dist_chain [0:PALETTE_ENTRIES];
   logic [INDEX_BITS-1:0]   best_idx_chain  [0:PALETTE_ENTRIES];
   logic [DIST_BITS-1:0]    pend_dist_chain [0:PALETTE_ENTRIES];

   logic advance;

   // channels keep only their low CHANNEL_BITS bits (zero extended when wider)
   logic [CHANNEL_BITS+npcs_pkg::FIELD_BITS-1:0] red_wide, green_wide, blue_wide;

   always_comb begin
      red_wide   = {{CHANNEL_BITS{1'b0}}, req_bus.red};
      green_wide = {{CHANNEL_BITS{1'b0}}, req_bus.green};
      blue_wide  = {{CHANNEL_BITS{1'b0}}, req_bus.blue};

      ctl_chain[0].valid       = req_bus.valid;
      ctl_chain[0].cmd         = npcs_pkg::cmd_type'(req_bus.command);
      ctl_chain[0].have        = 1'b0;
      ctl_chain[0].pend        = 1'b0;
      ctl_chain[0].entry_index = req_bus.entry_index;
      red_chain[0]             = red_wide[CHANNEL_BITS-1:0];
      green_chain[0]           = green_wide[CHANNEL_BITS-1:0];
      blue_chain[0]            = blue_wide[CHANNEL_BITS-1:0];
      best_dist_chain[0]       = '0;
      best_idx_chain[0]        = '0;
      pend_dist_chain[0]       = '0;
   end

   // a transaction is taken whenever the chain moves
   assign req_bus.ready = advance;

   // one cell per palette entry; writes and maps travel in order, so a map
   // sees exactly the writes that were accepted ahead of it
   for (genvar gi = 0; gi < PALETTE_ENTRIES; gi++) begin : g_cell
      npcs_cell #(
         .CELL_INDEX   (gi),
         .CHANNEL_BITS (CHANNEL_BITS),
         .INDEX_BITS   (INDEX_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .color_count (color_count_ff),
         .ctl_i       (ctl_chain[gi]),
         .red_i       (red_chain[gi]),
         .green_i     (green_chain[gi]),
         .blue_i      (blue_chain[gi]),
         .best_dist_i (best_dist_chain[gi]),
         .best_idx_i  (best_idx_chain[gi]),
         .pend_dist_i (pend_dist_chain[gi]),
         .ctl_o       (ctl_chain[gi+1]),
         .red_o       (red_chain[gi+1]),
         .green_o     (green_chain[gi+1]),
         .blue_o      (blue_chain[gi+1]),
         .best_dist_o (best_dist_chain[gi+1]),
         .best_idx_o  (best_idx_chain[gi+1]),
         .pend_dist_o (pend_dist_chain[gi+1])
      );
   end

   // last fold plus output register; also owns the chain-wide advance
   npcs_tail #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .CHANNEL_BITS    (CHANNEL_BITS),
      .INDEX_BITS      (INDEX_BITS)
   ) u_tail (
      .clock       (clock),
      .reset       (reset),
      .ctl_i       (ctl_chain[PALETTE_ENTRIES]),
      .best_dist_i (best_dist_chain[PALETTE_ENTRIES]),
      .best_idx_i  (best_idx_chain[PALETTE_ENTRIES]),
      .pend_dist_i (pend_dist_chain[PALETTE_ENTRIES]),
      .advance     (advance),
      .rsp_bus     (rsp_bus)
   );

endmodule
